[design/mag_agf_pkg.sv]
// Shared types, constants and helpers for the magnetometer auto-gain filter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mag_agf_pkg;

    // Number of sensor channels with their own filter state.
    localparam int CHANNELS = 2;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 7;
    localparam int MOVE_W   = 2;
    localparam int AVG_W    = 14;
    localparam int ACT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MAX    = 2'd2;

    // Configuration reset values.
    localparam logic [SAMPLE_W-1:0] UPPER_LIMIT_RST = 10'd793;
    localparam logic [SAMPLE_W-1:0] LOWER_LIMIT_RST = 10'd230;
    localparam logic [GAIN_W-1:0]   GAIN_MAX_RST    = 7'd100;

    // Per-channel state reset value of the gain step.
    localparam logic [GAIN_W-1:0] GAIN_RST = 7'd50;

    // Saturation limits.
    localparam logic [AVG_W-1:0] AVG_MAX = 14'h3fff;
    localparam logic [ACT_W-1:0] ACT_MAX = 15'h7fff;

    // Gain move codes.
    localparam logic [MOVE_W-1:0] MOVE_HOLD  = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_RAISE = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_LOWER = 2'd2;

    // Configuration register set.
    typedef struct packed {
        logic [SAMPLE_W-1:0] upper_limit;
        logic [SAMPLE_W-1:0] lower_limit;
        logic [GAIN_W-1:0]   gain_max;
    } cfg_t;

    // Filter state of one channel.
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [AVG_W-1:0]  fast;
        logic [AVG_W-1:0]  slow;
        logic [ACT_W-1:0]  act;
    } chan_state_t;

    // Map the incoming channel number onto a state index (wraps modulo CHANNELS).
    function automatic logic [IDX_W-1:0] chan_index(input logic sel);
        if (CHANNELS == 1) begin
            return '0;
        end else begin
            return IDX_W'(sel);
        end
    endfunction

endpackage

[design/mag_agf_cfg.sv]
// Configuration register file of the magnetometer auto-gain filter.
// Depends on mag_agf_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module mag_agf_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [mag_agf_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [mag_agf_pkg::CFG_DATA_W-1:0] wr_data,
    output mag_agf_pkg::cfg_t                  cfg
);
    import mag_agf_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.upper_limit <= UPPER_LIMIT_RST;
            cfg_reg.lower_limit <= LOWER_LIMIT_RST;
            cfg_reg.gain_max    <= GAIN_MAX_RST;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_UPPER_LIMIT: cfg_reg.upper_limit <= wr_data[SAMPLE_W-1:0];
                REG_LOWER_LIMIT: cfg_reg.lower_limit <= wr_data[SAMPLE_W-1:0];
                REG_GAIN_MAX:    cfg_reg.gain_max    <= wr_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/mag_agf_state.sv]
// Per-channel filter state store of the magnetometer auto-gain filter.
// Depends on mag_agf_pkg for chan_state_t and the channel count.
`timescale 1ns / 1ps

module mag_agf_state (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mag_agf_pkg::IDX_W-1:0] rd_idx,
    output mag_agf_pkg::chan_state_t      rd_state,
    input  logic                          wr_en,
    input  logic [mag_agf_pkg::IDX_W-1:0] wr_idx,
    input  mag_agf_pkg::chan_state_t      wr_state
);
    import mag_agf_pkg::*;

    chan_state_t state_reg [CHANNELS];

    // State update for the channel of the item leaving the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i].gain <= GAIN_RST;
                state_reg[i].fast <= '0;
                state_reg[i].slow <= '0;
                state_reg[i].act  <= '0;
            end
        end else if (wr_en) begin
            state_reg[wr_idx] <= wr_state;
        end
    end

    assign rd_state = state_reg[rd_idx];

endmodule

[design/mag_agf_update.sv]
// Per-item update logic: gain stepping, cascaded leaky averages and activity envelope.
// Depends on mag_agf_pkg for cfg_t, chan_state_t, limits and move codes.
`timescale 1ns / 1ps

module mag_agf_update (
    input  mag_agf_pkg::cfg_t                   cfg,
    input  logic [mag_agf_pkg::SAMPLE_W-1:0]    sample,
    input  mag_agf_pkg::chan_state_t            cur,
    output mag_agf_pkg::chan_state_t            nxt,
    output logic [mag_agf_pkg::MOVE_W-1:0]      move
);
    import mag_agf_pkg::*;

    logic [GAIN_W-1:0] gain_new;
    logic [AVG_W:0]   fast_sum;
    logic [AVG_W-1:0] fast_new;
    logic [AVG_W:0]   slow_sum;
    logic [AVG_W-1:0] slow_new;
    logic [AVG_W-1:0] diff;
    logic [ACT_W:0]   act_sum;
    logic [ACT_W-1:0] act_new;

    // Gain step: the raise test has priority over the lower test.
    always_comb begin
        gain_new = cur.gain;
        move     = MOVE_HOLD;
        priority if (sample > cfg.upper_limit && cur.gain < cfg.gain_max) begin
            gain_new = cur.gain + GAIN_W'(1);
            move     = MOVE_RAISE;
        end else if (sample < cfg.lower_limit && cur.gain != '0) begin
            gain_new = cur.gain - GAIN_W'(1);
            move     = MOVE_LOWER;
        end else begin
            gain_new = cur.gain;
            move     = MOVE_HOLD;
        end
    end

    // Fast average decays by 1/16 and adds the reading.
    assign fast_sum = {1'b0, cur.fast} - (AVG_W+1)'(cur.fast[AVG_W-1:4])
                      + (AVG_W+1)'(sample);
    assign fast_new = (fast_sum > (AVG_W+1)'(AVG_MAX)) ? AVG_MAX : fast_sum[AVG_W-1:0];

    // Slow average decays by 1/64 and adds the new fast average over 64.
    assign slow_sum = {1'b0, cur.slow} - (AVG_W+1)'(cur.slow[AVG_W-1:6])
                      + (AVG_W+1)'(fast_new[AVG_W-1:6]);
    assign slow_new = (slow_sum > (AVG_W+1)'(AVG_MAX)) ? AVG_MAX : slow_sum[AVG_W-1:0];

    // Activity decays by 1/128, adds a quarter of |fast - slow| and saturates.
    assign diff    = (fast_new >= slow_new) ? (fast_new - slow_new) : (slow_new - fast_new);
    assign act_sum = {1'b0, cur.act} - (ACT_W+1)'(cur.act[ACT_W-1:7])
                     + (ACT_W+1)'(diff[AVG_W-1:2]);
    assign act_new = (act_sum > (ACT_W+1)'(ACT_MAX)) ? ACT_MAX : act_sum[ACT_W-1:0];

    assign nxt = '{gain: gain_new, fast: fast_new, slow: slow_new, act: act_new};

endmodule

[design/magnetometer_auto_gain_filter_top.sv]
// Top level of the magnetometer auto-gain filter.
// Depends on mag_agf_pkg, mag_agf_cfg, mag_agf_state and mag_agf_update.
`timescale 1ns / 1ps

// Usage:
// The s_ channel takes one item per reading: a channel number and a 10-bit
// sample. The m_ channel returns exactly one item per reading with the
// channel, its updated gain step, the gain move code, both leaky averages
// and the activity envelope. The cfg_ channel writes the upper limit,
// lower limit and gain maximum; it is always ready and should be used
// only while no items are in flight.
// Items pass the input register, then the result register, to the m_ ports.
// Throughput: one item per cycle unless the receiver stalls, set by the
// single update pass that reads and rewrites the channel state between
// the input and result registers; back-to-back items on the same channel
// see each other's updates.
// Reset (synchronous, aresetn low) restores the default limits, sets every
// gain step to 50 and clears all averages and envelopes; both registers empty.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item before s_ready drops.
module magnetometer_auto_gain_filter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mag_agf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mag_agf_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_chan_sel,
    input  logic [mag_agf_pkg::SAMPLE_W-1:0]   s_sample,
    // Result channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_out_chan,
    output logic [mag_agf_pkg::GAIN_W-1:0]     m_gain_step,
    output logic [mag_agf_pkg::MOVE_W-1:0]     m_gain_move,
    output logic [mag_agf_pkg::AVG_W-1:0]      m_fast_avg,
    output logic [mag_agf_pkg::AVG_W-1:0]      m_slow_avg,
    output logic [mag_agf_pkg::ACT_W-1:0]      m_activity
);
    import mag_agf_pkg::*;

    cfg_t        cfg;
    chan_state_t cur_state;
    chan_state_t nxt_state;
    logic [MOVE_W-1:0] move;

    // Input register.
    logic                in_valid_reg;
    logic [IDX_W-1:0]    in_idx_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_chan_reg;
    chan_state_t       out_state_reg;
    logic [MOVE_W-1:0] out_move_reg;

    logic advance;
    logic s_accept;

    assign cfg_ready = 1'b1;

    mag_agf_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mag_agf_state u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (in_idx_reg),
        .rd_state (cur_state),
        .wr_en    (advance),
        .wr_idx   (in_idx_reg),
        .wr_state (nxt_state)
    );

    mag_agf_update u_update (
        .cfg    (cfg),
        .sample (in_sample_reg),
        .cur    (cur_state),
        .nxt    (nxt_state),
        .move   (move)
    );

    // Handshake: the item in the input register moves on when the result
    // register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_idx_reg    <= chan_index(s_chan_sel);
            in_sample_reg <= s_sample;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_chan_reg  <= in_idx_reg[0];
            out_state_reg <= nxt_state;
            out_move_reg  <= move;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_chan  = out_chan_reg;
    assign m_gain_step = out_state_reg.gain;
    assign m_gain_move = out_move_reg;
    assign m_fast_avg  = out_state_reg.fast;
    assign m_slow_avg  = out_state_reg.slow;
    assign m_activity  = out_state_reg.act;

endmodule

[dv/magnetometer_auto_gain_filter_top_tb.sv]
// Self-checking testbench for the magnetometer auto-gain filter top level.
// Depends on mag_agf_pkg and magnetometer_auto_gain_filter_top; needs no other file.
`timescale 1ns / 1ps

module magnetometer_auto_gain_filter_top_tb;
    import mag_agf_pkg::*;

    // One result item as it appears on the m_ ports.
    typedef struct packed {
        logic              chan;
        logic [GAIN_W-1:0] gain;
        logic [MOVE_W-1:0] move;
        logic [AVG_W-1:0]  fast;
        logic [AVG_W-1:0]  slow;
        logic [ACT_W-1:0]  act;
    } reading_t;

    // One row of the directed table: a reading or a register write.
    typedef enum logic [0:0] {ROW_READING, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic                  chan;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        reading_t              want;
    } step_row_t;

    // Settings of the limit registers for one random phase.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] upper;
        logic [CFG_DATA_W-1:0] lower;
        logic [CFG_DATA_W-1:0] gmax;
    } limits_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int DIR_ROWS     = 21;
    localparam int PHASE_COUNT  = 7;
    localparam int RANDOM_PHASE = 5;
    localparam int PHASE_ITEMS  = 86;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 64;

    // Typed expectations come from the reset state and the earlier rows of each channel.
    localparam step_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{ROW_READING, REG_SPARE, 1'b0, 10'd0, 1'b1,
          '{1'b0, 7'd49, MOVE_LOWER, 14'd0, 14'd0, 15'd0}},
        '{ROW_READING, REG_SPARE, 1'b1, 10'd1023, 1'b1,
          '{1'b1, 7'd51, MOVE_RAISE, 14'd1023, 14'd15, 15'd252}},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd230, 1'b1,
          '{1'b0, 7'd49, MOVE_HOLD, 14'd230, 14'd3, 15'd56}},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd793, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd794, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b1, 10'd229, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_MAX, 1'b0, 10'd10, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b1, 10'd1023, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b1, 10'd0, 1'b0, '0},
        '{ROW_WRITE, REG_UPPER_LIMIT, 1'b0, 10'd0, 1'b0, '0},
        '{ROW_WRITE, REG_LOWER_LIMIT, 1'b0, 10'd1023, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_MAX, 1'b0, 10'd49, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd500, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd500, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd500, 1'b0, '0},
        '{ROW_WRITE, REG_UPPER_LIMIT, 1'b0, 10'd1023, 1'b0, '0},
        '{ROW_WRITE, REG_LOWER_LIMIT, 1'b0, 10'd0, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd1023, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b1, 10'd0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE, 1'b0, 10'h3ff, 1'b0, '0},
        '{ROW_READING, REG_SPARE, 1'b0, 10'd512, 1'b0, '0}
    };

    // Phase settings: all raising, all lowering, crossed limits, frozen gain,
    // gain above its maximum, random, and the defaults with a wide gain write.
    localparam limits_t PHASES [0:PHASE_COUNT-1] = '{
        '{10'd0, 10'd0, 10'd127},
        '{10'd1023, 10'd1023, 10'd127},
        '{10'd0, 10'd1023, 10'd127},
        '{10'd1023, 10'd0, 10'd0},
        '{10'd300, 10'd700, 10'd20},
        '{10'd0, 10'd0, 10'd0},
        '{10'd793, 10'd230, 10'h3e4}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_chan_sel = 1'b0;
    logic [SAMPLE_W-1:0]   s_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_out_chan;
    logic [GAIN_W-1:0]     m_gain_step;
    logic [MOVE_W-1:0]     m_gain_move;
    logic [AVG_W-1:0]      m_fast_avg;
    logic [AVG_W-1:0]      m_slow_avg;
    logic [ACT_W-1:0]      m_activity;

    // Filter model: limits and per-channel state.
    cfg_t        limits;
    chan_state_t filt_state [CHANNELS];
    reading_t    pending_readings [$];

    // Typed expectation attached to the item now offered on the s_ channel.
    logic     hint_typed = 1'b0;
    reading_t hint_reading = '0;

    int errors = 0;
    int n_readings = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_raise = 0;
    int n_lower = 0;
    int n_act_sat = 0;
    int peak_fast = 0;
    int idle_cycles = 0;

    magnetometer_auto_gain_filter_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_chan_sel  (s_chan_sel),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_chan  (m_out_chan),
        .m_gain_step (m_gain_step),
        .m_gain_move (m_gain_move),
        .m_fast_avg  (m_fast_avg),
        .m_slow_avg  (m_slow_avg),
        .m_activity  (m_activity)
    );

    always #6 aclk = ~aclk;

    // Update the channel's state with one reading and return what it reports.
    function automatic reading_t filter_reading(input logic chan, input logic [SAMPLE_W-1:0] smp);
        int unsigned ch;
        int unsigned g;
        int unsigned f;
        int unsigned s;
        int unsigned a;
        int unsigned d;
        reading_t r;
        ch = int'(chan) % CHANNELS;
        g = filt_state[ch].gain;
        f = filt_state[ch].fast;
        s = filt_state[ch].slow;
        a = filt_state[ch].act;
        r.move = MOVE_HOLD;
        // The raise test wins; the lower test is made only when it fails.
        if (smp > limits.upper_limit && g < limits.gain_max) begin
            g = (g + 1) & 'h7f;
            r.move = MOVE_RAISE;
        end else if (smp < limits.lower_limit && g > 0) begin
            g = g - 1;
            r.move = MOVE_LOWER;
        end
        f = f - (f >> 4) + smp;
        if (f > AVG_MAX) f = AVG_MAX;
        s = s - (s >> 6) + (f >> 6);
        if (s > AVG_MAX) s = AVG_MAX;
        d = (f >= s) ? f - s : s - f;
        a = a - (a >> 7) + (d >> 2);
        if (a > ACT_MAX) a = ACT_MAX;
        filt_state[ch].gain = g[GAIN_W-1:0];
        filt_state[ch].fast = f[AVG_W-1:0];
        filt_state[ch].slow = s[AVG_W-1:0];
        filt_state[ch].act  = a[ACT_W-1:0];
        r.chan = ch[0];
        r.gain = g[GAIN_W-1:0];
        r.fast = f[AVG_W-1:0];
        r.slow = s[AVG_W-1:0];
        r.act  = a[ACT_W-1:0];
        return r;
    endfunction

    // Gap before the next item: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", n_checked, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Offer one reading and hold it until it is accepted.
    task automatic send_reading(input logic chan, input logic [SAMPLE_W-1:0] smp,
                                input logic typed, input reading_t want);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_chan_sel   <= chan;
        s_sample     <= smp;
        hint_typed   = typed;
        hint_reading = want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Write one register once every item in flight has come out.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random readings in bursts: noise, high runs, low runs and a square wave.
    task automatic run_phase(input int count);
        int left;
        int blen;
        int shape;
        int gap;
        logic fixed_ch;
        logic quiet;
        logic ch;
        logic [SAMPLE_W-1:0] smp;
        left = count;
        while (left > 0) begin
            blen = $urandom_range(4, 60);
            if (blen > left) blen = left;
            shape = $urandom_range(0, 3);
            fixed_ch = 1'($urandom_range(0, 1));
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < blen; i++) begin
                ch = (shape == 0) ? 1'($urandom_range(0, 1)) : fixed_ch;
                case (shape)
                    0: smp = SAMPLE_W'($urandom_range(0, 1023));
                    1: smp = SAMPLE_W'(1023 - $urandom_range(0, 15));
                    2: smp = SAMPLE_W'($urandom_range(0, 15));
                    default: smp = (i % 8 < 4) ? 10'd1023 : 10'd0;
                endcase
                send_reading(ch, smp, 1'b0, '0);
                gap = quiet ? 0 : pick_gap();
                pause_sender(gap);
            end
            left -= blen;
        end
    endtask

    // Track writes and accepted readings; compare every result item in order.
    always @(posedge aclk) begin : monitor
        reading_t want;
        reading_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_writes++;
                case (cfg_index)
                    REG_UPPER_LIMIT: limits.upper_limit = cfg_data;
                    REG_LOWER_LIMIT: limits.lower_limit = cfg_data;
                    REG_GAIN_MAX:    limits.gain_max = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = filter_reading(s_chan_sel, s_sample);
                if (hint_typed) want = hint_reading;
                pending_readings.push_back(want);
                n_readings++;
            end
            if (m_valid && m_ready) begin
                got = '{m_out_chan, m_gain_step, m_gain_move, m_fast_avg, m_slow_avg,
                        m_activity};
                if (pending_readings.size() == 0) begin
                    report_mismatch("result item with no reading outstanding");
                end else begin
                    want = pending_readings.pop_front();
                    check_field("out_chan", 32'(got.chan), 32'(want.chan));
                    check_field("gain_step", 32'(got.gain), 32'(want.gain));
                    check_field("gain_move", 32'(got.move), 32'(want.move));
                    check_field("fast_avg", 32'(got.fast), 32'(want.fast));
                    check_field("slow_avg", 32'(got.slow), 32'(want.slow));
                    check_field("activity", 32'(got.act), 32'(want.act));
                    if (want.move == MOVE_RAISE) n_raise++;
                    if (want.move == MOVE_LOWER) n_lower++;
                    if (want.act == ACT_MAX) n_act_sat++;
                    if (int'(want.fast) > peak_fast) peak_fast = int'(want.fast);
                end
                n_checked++;
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, quiet windows, and one long hold-off.
    initial begin : receiver
        int stall;
        int rx_turn;
        logic held;
        rx_turn = 0;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && n_checked >= 200) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end else if ((rx_turn / 200) % 3 == 0) begin
                stall = 0;
            end else begin
                stall = pick_gap();
            end
            rx_turn++;
            @(negedge aclk);
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Stimulus: reset, the directed table, then the random phases.
    initial begin : stimulus
        limits_t lim;
        limits.upper_limit = UPPER_LIMIT_RST;
        limits.lower_limit = LOWER_LIMIT_RST;
        limits.gain_max    = GAIN_MAX_RST;
        for (int c = 0; c < CHANNELS; c++)
            filt_state[c] = '{GAIN_RST, '0, '0, '0};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                send_reading(DIRECTED[i].chan, DIRECTED[i].data, DIRECTED[i].typed,
                             DIRECTED[i].want);
                pause_sender(pick_gap());
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            lim = PHASES[p];
            if (p == RANDOM_PHASE) begin
                lim = '{CFG_DATA_W'($urandom_range(0, 1023)),
                        CFG_DATA_W'($urandom_range(0, 1023)),
                        CFG_DATA_W'($urandom_range(0, 1023))};
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 1023)));
            end
            write_reg(REG_UPPER_LIMIT, lim.upper);
            write_reg(REG_LOWER_LIMIT, lim.lower);
            write_reg(REG_GAIN_MAX, lim.gmax);
            run_phase(PHASE_ITEMS);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d readings and %0d register writes through %0d limit settings.",
                 n_readings, n_writes, PHASE_COUNT + 4);
        $display("Compared %0d results: %0d gain raises, %0d lowers, %0d saturated, fast peak %0d.",
                 n_checked, n_raise, n_lower, n_act_sat, peak_fast);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/mag_agf_pkg.sv
design/mag_agf_cfg.sv
design/mag_agf_state.sv
design/mag_agf_update.sv
design/magnetometer_auto_gain_filter_top.sv
dv/magnetometer_auto_gain_filter_top_tb.sv
